// ===== rtl/masked_code_fingerprint_hash_defines.svh =====
// Assertion helpers for the RTL; every check is clocked on clk and
// held off while rst_n is low.
`ifndef MASKED_CODE_FINGERPRINT_HASH_DEFINES_SVH
`define MASKED_CODE_FINGERPRINT_HASH_DEFINES_SVH

// Same-cycle implication.
`define MCFH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCFH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mcfh_pkg.sv =====
package mcfh_pkg;

  localparam int DataW      = 32;
  localparam int LenW       = 24;
  localparam int HashW      = 64;
  localparam int NumLengths = 6;
  localparam int CfgIdxW    = 3;

  localparam logic [HashW-1:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMode = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLen0 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLen5 = 3'd6;

  typedef enum logic [1:0] {
    KIND_PREFIX = 2'd0,
    KIND_WHOLE  = 2'd1,
    KIND_SHORT  = 2'd2
  } mcfh_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_PREFIX,
    ST_FINAL
  } mcfh_state_t;

  typedef struct packed {
    logic fold;
    logic init;
  } mcfh_hash_ctl_t;

  // Clear the link-dependent immediate fields of branches, ADR/ADRP and
  // literal loads so the fingerprint does not depend on placement.
  function automatic logic [DataW-1:0] mask_position(input logic [DataW-1:0] w);
    logic [DataW-1:0] r;
    r = w;
    if ((w & 32'hFC00_0000) == 32'h9400_0000 || (w & 32'hFC00_0000) == 32'h1400_0000) begin
      r = w & 32'hFC00_0000;
    end else if ((w & 32'hFF00_0010) == 32'h5400_0000) begin
      r = w & 32'hFF00_001F;
    end else if ((w & 32'h7E00_0000) == 32'h3400_0000) begin
      r = w & 32'hFF00_001F;
    end else if ((w & 32'h7E00_0000) == 32'h3600_0000) begin
      r = w & 32'hFFF8_001F;
    end else if ((w & 32'h1F00_0000) == 32'h1000_0000) begin
      r = w & 32'h9F00_001F;
    end else if ((w & 32'h3B00_0000) == 32'h1800_0000) begin
      r = w & 32'hFF00_00FF;
    end
    return r;
  endfunction

endpackage

// ===== rtl/mcfh_hash_core.sv =====
// One FNV-1a round per fold cycle on the running 64-bit hash.
module mcfh_hash_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcfh_pkg::mcfh_hash_ctl_t      ctl,
  input  logic [7:0]                    fold_byte,
  output logic [mcfh_pkg::HashW-1:0]    acc
);

  logic [mcfh_pkg::HashW-1:0] acc_r;
  logic [mcfh_pkg::HashW-1:0] acc_nxt;
  logic [mcfh_pkg::HashW-1:0] x;
  logic [mcfh_pkg::HashW-1:0] prod;

  // Prime is 2^40 + 0x1b3: multiply as a sum of shifted copies.
  always_comb begin
    x    = acc_r ^ {56'd0, fold_byte};
    prod = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.init) begin
      acc_nxt = mcfh_pkg::FnvBasis;
    end else if (ctl.fold) begin
      acc_nxt = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= mcfh_pkg::FnvBasis;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/masked_code_fingerprint_hash.sv =====
// Code fingerprint hasher: folds a body of AArch64 words (placement-dependent
// fields masked) or raw bytes into a 64-bit FNV-1a hash, reporting prefix
// hashes at the configured lengths and the whole-body hash on the last item,
// both only if the body is 8 bytes or more (else a short result, hash zero).
// One request at a time goes through a single FNV round unit, one byte per
// cycle: a word request takes four byte rounds, a byte request one, a request
// past the body none. The user must see that configuration is written only
// while no request is in flight; the block itself does not enforce this.
`include "masked_code_fingerprint_hash_defines.svh"

module masked_code_fingerprint_hash (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [mcfh_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [mcfh_pkg::LenW-1:0]         cfg_wdata,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mcfh_pkg::DataW-1:0]        in_data_word,
  input  logic [mcfh_pkg::LenW-1:0]         in_body_size,
  input  logic                              in_last_item,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_result_kind,
  output logic [mcfh_pkg::LenW-1:0]         out_covered_bytes,
  output logic [mcfh_pkg::HashW-1:0]        out_hash_value,
  output logic                              out_last_result
);

  localparam int LenW  = mcfh_pkg::LenW;
  localparam int HashW = mcfh_pkg::HashW;
  localparam int DataW = mcfh_pkg::DataW;

  // configuration registers
  logic                                   mode_r;
  logic [LenW-1:0]                        len_r [mcfh_pkg::NumLengths];

  // sequencer and request state
  mcfh_pkg::mcfh_state_t                  state_r, state_nxt;
  logic [1:0]                             byte_idx_r, byte_idx_nxt;
  logic [DataW-1:0]                       word_r, word_nxt;
  logic [LenW-1:0]                        size_r, size_nxt;
  logic                                   last_r, last_nxt;
  logic [LenW-1:0]                        cnt_new_r, cnt_new_nxt;
  logic [LenW-1:0]                        byte_cnt_r, byte_cnt_nxt;

  // output register
  logic                                   out_valid_r, out_valid_nxt;
  mcfh_pkg::mcfh_kind_t                   out_kind_r, out_kind_nxt;
  logic [LenW-1:0]                        out_covered_r, out_covered_nxt;
  logic [HashW-1:0]                       out_hash_r, out_hash_nxt;
  logic                                   out_last_r, out_last_nxt;

  logic                                   accept;
  logic                                   slot_free;
  logic                                   out_load;
  logic                                   in_body;
  logic                                   big_body;
  logic                                   hit;
  logic [LenW:0]                          cnt_sum;
  logic [LenW:0]                          step;
  logic [HashW-1:0]                       acc;
  mcfh_pkg::mcfh_hash_ctl_t               hash_ctl;

  mcfh_hash_core u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hash_ctl),
    .fold_byte (word_r[7:0]),
    .acc       (acc)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      for (int i = 0; i < mcfh_pkg::NumLengths; i++) begin
        len_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == mcfh_pkg::CfgMode) begin
        mode_r <= cfg_wdata[0];
      end
      for (int i = 0; i < mcfh_pkg::NumLengths; i++) begin
        if (cfg_index == mcfh_pkg::CfgLen0 + mcfh_pkg::CfgIdxW'(i)) begin
          len_r[i] <= cfg_wdata;
        end
      end
    end
  end

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign step      = mode_r ? (LenW+1)'(4) : (LenW+1)'(1);
  assign cnt_sum   = {1'b0, byte_cnt_r} + step;
  assign in_body   = cnt_sum <= {1'b0, in_body_size};
  assign big_body  = size_r[LenW-1:3] != '0;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < mcfh_pkg::NumLengths; i++) begin
      if (len_r[i] != '0 && len_r[i] == cnt_new_r) begin
        hit = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcfh_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_body) begin
            state_nxt = mcfh_pkg::ST_FOLD;
          end else if (in_last_item) begin
            state_nxt = mcfh_pkg::ST_FINAL;
          end
        end
      end
      mcfh_pkg::ST_FOLD: begin
        if (byte_idx_r == 2'd0) begin
          priority if (hit && big_body) begin
            state_nxt = mcfh_pkg::ST_PREFIX;
          end else if (last_r) begin
            state_nxt = mcfh_pkg::ST_FINAL;
          end else begin
            state_nxt = mcfh_pkg::ST_IDLE;
          end
        end
      end
      mcfh_pkg::ST_PREFIX: begin
        if (slot_free) begin
          state_nxt = last_r ? mcfh_pkg::ST_FINAL : mcfh_pkg::ST_IDLE;
        end
      end
      mcfh_pkg::ST_FINAL: begin
        if (slot_free) begin
          state_nxt = mcfh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcfh_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = 1'b1;
    out_load      = 1'b0;
    hash_ctl      = '0;
    byte_idx_nxt  = byte_idx_r;
    word_nxt      = word_r;
    size_nxt      = size_r;
    last_nxt      = last_r;
    cnt_new_nxt   = cnt_new_r;
    byte_cnt_nxt  = byte_cnt_r;
    out_kind_nxt    = out_kind_r;
    out_covered_nxt = out_covered_r;
    out_hash_nxt    = out_hash_r;
    out_last_nxt    = out_last_r;
    unique case (state_r)
      mcfh_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          word_nxt     = mode_r ? mcfh_pkg::mask_position(in_data_word) : in_data_word;
          size_nxt     = in_body_size;
          last_nxt     = in_last_item;
          cnt_new_nxt  = cnt_sum[LenW-1:0];
          byte_idx_nxt = mode_r ? 2'd3 : 2'd0;
        end
      end
      mcfh_pkg::ST_FOLD: begin
        hash_ctl.fold = 1'b1;
        word_nxt      = word_r >> 8;
        byte_idx_nxt  = byte_idx_r - 2'd1;
        if (byte_idx_r == 2'd0) begin
          byte_cnt_nxt = cnt_new_r;
        end
      end
      mcfh_pkg::ST_PREFIX: begin
        if (slot_free) begin
          out_load        = 1'b1;
          out_kind_nxt    = mcfh_pkg::KIND_PREFIX;
          out_covered_nxt = byte_cnt_r;
          out_hash_nxt    = acc;
          out_last_nxt    = !last_r;
        end
      end
      mcfh_pkg::ST_FINAL: begin
        if (slot_free) begin
          out_load        = 1'b1;
          out_kind_nxt    = big_body ? mcfh_pkg::KIND_WHOLE : mcfh_pkg::KIND_SHORT;
          out_covered_nxt = byte_cnt_r;
          out_hash_nxt    = big_body ? acc : '0;
          out_last_nxt    = 1'b1;
          // start a new body
          hash_ctl.init   = 1'b1;
          byte_cnt_nxt    = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcfh_pkg::ST_IDLE;
      byte_idx_r  <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_idx_r  <= byte_idx_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r        <= word_nxt;
    size_r        <= size_nxt;
    last_r        <= last_nxt;
    cnt_new_r     <= cnt_new_nxt;
    out_kind_r    <= out_kind_nxt;
    out_covered_r <= out_covered_nxt;
    out_hash_r    <= out_hash_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_covered_bytes = out_covered_r;
  assign out_hash_value    = out_hash_r;
  assign out_last_result   = out_last_r;

  `MCFH_ASSERT_NOW(a_fold_within_body, state_r == mcfh_pkg::ST_FOLD, cnt_new_r <= size_r, "fold past the end of the body")
  `MCFH_ASSERT_NEXT(a_final_restarts, state_r == mcfh_pkg::ST_FINAL && out_load, byte_cnt_r == '0 && state_r == mcfh_pkg::ST_IDLE && acc == mcfh_pkg::FnvBasis, "body state not restarted after final result")
  `MCFH_ASSERT_NOW(a_short_zero_hash, out_valid_r && out_kind_r == mcfh_pkg::KIND_SHORT, out_hash_r == '0 && out_last_r, "short-body result malformed")
  `MCFH_ASSERT_NOW(a_prefix_nonzero, out_valid_r && out_kind_r == mcfh_pkg::KIND_PREFIX, out_covered_r != '0, "prefix result with nothing covered")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int DataW      = mcfh_pkg::DataW;
  localparam int LenW       = mcfh_pkg::LenW;
  localparam int HashW      = mcfh_pkg::HashW;
  localparam int NumLengths = mcfh_pkg::NumLengths;
  localparam int CfgIdxW    = mcfh_pkg::CfgIdxW;

  localparam int Limit       = 500_000;
  localparam int DrainCycles = 20;
  localparam int HoldLen     = 400;
  localparam int PhaseItems  = 210;
  localparam int NumPhases   = 8;

  localparam logic [HashW-1:0]   FnvPrime = 64'h0000_0100_0000_01b3;
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

  // opcode fields of the instructions whose link-dependent bits get cleared
  localparam logic [4:0] OpBranchImm  = 5'b00101;   // [30:26]: B, BL
  localparam logic [7:0] OpBranchCond = 8'h54;      // [31:24], bit 4 clear
  localparam logic [5:0] OpCmpBranch  = 6'b011010;  // [30:25]: CBZ, CBNZ
  localparam logic [5:0] OpTestBranch = 6'b011011;  // [30:25]: TBZ, TBNZ
  localparam logic [4:0] OpPcRel      = 5'b10000;   // [28:24]: ADR, ADRP
  localparam logic [2:0] OpLoadLit    = 3'b011;     // [29:27], [25:24] clear

  typedef enum logic [2:0] {
    INS_BRANCH,
    INS_BCOND,
    INS_CMP,
    INS_TEST,
    INS_PCREL,
    INS_LITERAL,
    INS_PLAIN
  } ins_class_t;

  typedef struct packed {
    mcfh_pkg::mcfh_kind_t kind;
    logic [LenW-1:0]      covered;
    logic [HashW-1:0]     hash;
    logic                 tail;
  } fp_result_t;

  typedef struct packed {
    logic [1:0]           phase;
    logic [DataW-1:0]     data;
    logic [LenW-1:0]      size;
    logic                 last;
    logic                 typed;
    mcfh_pkg::mcfh_kind_t kind;
    logic [LenW-1:0]      covered;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [LenW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DataW-1:0] in_data_word = '0;
  logic [LenW-1:0] in_body_size = '0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [LenW-1:0] out_covered_bytes;
  logic [HashW-1:0] out_hash_value;
  logic out_last_result;

  masked_code_fingerprint_hash dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_word      (in_data_word),
    .in_body_size      (in_body_size),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_covered_bytes (out_covered_bytes),
    .out_hash_value    (out_hash_value),
    .out_last_result   (out_last_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // fingerprint state mirrored from the block
  logic              word_mode = 1'b1;
  logic [LenW-1:0]   report_len [NumLengths];
  logic [HashW-1:0]  run_hash = mcfh_pkg::FnvBasis;
  logic [LenW-1:0]   run_bytes = '0;
  fp_result_t        step_res [2];
  int                step_n;

  fp_result_t fingerprints_due [$];
  int mismatches = 0;
  int cycles = 0;
  int items_in_phase = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_on = 1'b0;
  int held_cycles = 0;

  stim_row_t directed_rows [26] = '{
    // reset settings: word mode, no prefix lengths
    '{2'd0, 32'h0000_0000, 24'd0, 1'b1, 1'b1, mcfh_pkg::KIND_SHORT, 24'd0},
    '{2'd0, 32'hFFFF_FFFF, 24'd4, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd0, 32'h0000_0000, 24'd4, 1'b1, 1'b1, mcfh_pkg::KIND_SHORT, 24'd4},
    // word mode, lengths 8 twice, 6 (never reached), 40, 0, max
    '{2'd1, 32'h97FF_FFFF, 24'd40, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'h17FF_FFFF, 24'd40, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'h54FF_FFEF, 24'd40, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'h54FF_FFFF, 24'd40, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'hB5FF_FFFF, 24'd40, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'h37FF_FFFF, 24'd40, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'hF0FF_FFFF, 24'd40, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'h58FF_FFFF, 24'd40, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'h0000_0000, 24'd40, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'hFFFF_FFFF, 24'd40, 1'b1, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'h1234_5678, 24'd10, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'h9ABC_DEF0, 24'd10, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'h0F0F_0F0F, 24'd10, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd1, 32'hFFFF_FFFF, 24'd10, 1'b1, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    // byte mode, lengths 1 twice, 3, 8, 0, max
    '{2'd2, 32'hFFFF_FF00, 24'd8, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd2, 32'h0000_00FF, 24'd8, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd2, 32'hA5A5_A5A5, 24'd8, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd2, 32'h0000_005A, 24'd8, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd2, 32'h8000_00FF, 24'd8, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd2, 32'h0000_0000, 24'd8, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd2, 32'h5555_557E, 24'd8, 1'b0, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd2, 32'hAAAA_AA81, 24'd8, 1'b1, 1'b0, mcfh_pkg::KIND_PREFIX, 24'd0},
    '{2'd2, 32'hFFFF_FFFF, 24'd7, 1'b1, 1'b1, mcfh_pkg::KIND_SHORT, 24'd1}
  };

  function automatic logic [DataW-1:0] strip_link_fields(input logic [DataW-1:0] w);
    if (w[30:26] == OpBranchImm) return {w[31:26], 26'd0};
    if (w[31:24] == OpBranchCond && !w[4]) return {w[31:24], 19'd0, w[4:0]};
    if (w[30:25] == OpCmpBranch) return {w[31:24], 19'd0, w[4:0]};
    if (w[30:25] == OpTestBranch) return {w[31:19], 14'd0, w[4:0]};
    if (w[28:24] == OpPcRel) return {w[31], 2'd0, w[28:24], 19'd0, w[4:0]};
    if (w[29:27] == OpLoadLit && w[25:24] == 2'b00) return {w[31:24], 16'd0, w[7:0]};
    return w;
  endfunction

  function automatic logic [HashW-1:0] fnv_round(input logic [HashW-1:0] h,
                                                 input logic [7:0] b);
    return (h ^ {56'd0, b}) * FnvPrime;
  endfunction

  // append one expected result at the back of the scoreboard
  function automatic void queue_result(input fp_result_t r);
    fingerprints_due = {fingerprints_due, r};
  endfunction

  // advance the mirrored fingerprint by one request; results land in step_res
  task automatic hash_request(input logic [DataW-1:0] data, input logic [LenW-1:0] size,
                              input logic last, input bit keep);
    logic [DataW-1:0] w;
    logic [LenW:0] reach;
    logic hit;
    step_n = 0;
    reach = {1'b0, run_bytes} + (word_mode ? 25'd4 : 25'd1);
    if (reach <= {1'b0, size}) begin
      if (word_mode) begin
        w = strip_link_fields(data);
        for (int b = 0; b < 4; b++) run_hash = fnv_round(run_hash, w[8*b +: 8]);
      end else begin
        run_hash = fnv_round(run_hash, data[7:0]);
      end
      run_bytes = reach[LenW-1:0];
      hit = 1'b0;
      for (int i = 0; i < NumLengths; i++)
        if (report_len[i] != '0 && report_len[i] == run_bytes) hit = 1'b1;
      if (size >= 8 && hit) begin
        step_res[step_n] = '{mcfh_pkg::KIND_PREFIX, run_bytes, run_hash, 1'b0};
        step_n++;
      end
    end
    if (last) begin
      if (size >= 8) step_res[step_n] = '{mcfh_pkg::KIND_WHOLE, run_bytes, run_hash, 1'b0};
      else step_res[step_n] = '{mcfh_pkg::KIND_SHORT, run_bytes, '0, 1'b0};
      step_n++;
      run_hash = mcfh_pkg::FnvBasis;
      run_bytes = '0;
    end
    if (step_n > 0) step_res[step_n-1].tail = 1'b1;
    if (keep)
      for (int i = 0; i < step_n; i++) queue_result(step_res[i]);
  endtask

  // present one request and hold it until the block takes it
  task automatic offer_request(input logic [DataW-1:0] data, input logic [LenW-1:0] size,
                               input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= data;
    in_body_size <= size;
    in_last_item <= last;
    do @(posedge clk); while (in_stall);
    items_in_phase++;
  endtask

  task automatic send_item(input logic [DataW-1:0] data, input logic [LenW-1:0] size,
                           input logic last);
    offer_request(data, size, last);
    hash_request(data, size, last, 1'b1);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == mcfh_pkg::CfgMode) word_mode = val[0];
    else if (idx >= mcfh_pkg::CfgLen0 && idx <= mcfh_pkg::CfgLen5)
      report_len[idx - mcfh_pkg::CfgLen0] = val;
  endtask

  task automatic configure(input logic mode, input logic [NumLengths-1:0][LenW-1:0] lens,
                           input bit spare);
    write_reg(mcfh_pkg::CfgMode, {23'($urandom), mode});
    for (int i = 0; i < NumLengths; i++) write_reg(3'(mcfh_pkg::CfgLen0 + i), lens[i]);
    if (spare) write_reg(CfgSpare, 24'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid, let every result drain, then give the block time to go idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (fingerprints_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_idling(input int profile);
    case (profile)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 51; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 51; end
      default: begin send_idle_pct = 13; stall_pct = 13; end
    endcase
  endtask

  function automatic logic [LenW-1:0] pick_length(input logic wmode);
    case ($urandom_range(9))
      0: return '0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom);
      3: return 24'($urandom_range(1, 60));
      default: return wmode ? 24'(4 * $urandom_range(2, 20)) : 24'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [DataW-1:0] random_instruction();
    logic [DataW-1:0] w;
    w = $urandom;
    case (ins_class_t'($urandom_range(6)))
      INS_BRANCH:  w[30:26] = OpBranchImm;
      INS_BCOND:   w[31:24] = OpBranchCond;
      INS_CMP:     w[30:25] = OpCmpBranch;
      INS_TEST:    w[30:25] = OpTestBranch;
      INS_PCREL:   w[28:24] = OpPcRel;
      INS_LITERAL: begin
        w[29:27] = OpLoadLit;
        w[25:24] = 2'b00;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_body();
    int shape;
    int units;
    int n;
    logic [LenW-1:0] size;
    shape = $urandom_range(19);
    if (shape == 0) begin
      // noise: body size changes from request to request
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) send_item($urandom, 24'($urandom), k == n - 1);
    end else begin
      if (shape == 1) begin
        size = 24'($urandom_range(0, 7));
        n = $urandom_range(1, 3);
      end else if (shape == 2) begin
        size = 24'hFF_FFFF;
        n = $urandom_range(1, 6);
      end else begin
        units = $urandom_range(2, word_mode ? 24 : 48);
        size = word_mode ? 24'(4 * units) : 24'(units);
        if (word_mode && $urandom_range(3) == 0) size += 24'($urandom_range(1, 3));
        n = units;
        if ($urandom_range(4) == 0) n += $urandom_range(1, 2);
        else if ($urandom_range(9) == 0) n = $urandom_range(1, units);
      end
      for (int k = 0; k < n; k++)
        send_item(word_mode ? random_instruction() : $urandom, size, k == n - 1);
    end
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_on && held_cycles < HoldLen) begin
      out_stall <= 1'b1;
      held_cycles <= held_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    fp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fingerprints_due.size() == 0) begin
        $error("unexpected result: kind %0d covered %0d hash %h",
               out_result_kind, out_covered_bytes, out_hash_value);
        mismatches++;
      end else begin
        want = fingerprints_due.pop_front();
        if (out_result_kind !== want.kind) begin
          $error("result_kind expected %0d actual %0d", want.kind, out_result_kind);
          mismatches++;
        end
        if (out_covered_bytes !== want.covered) begin
          $error("covered_bytes expected %0d actual %0d", want.covered, out_covered_bytes);
          mismatches++;
        end
        if (out_hash_value !== want.hash) begin
          $error("hash_value expected %h actual %h", want.hash, out_hash_value);
          mismatches++;
        end
        if (out_last_result !== want.tail) begin
          $error("last_result expected %0d actual %0d", want.tail, out_last_result);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [1:0] cur_phase;
    logic mode;
    logic [NumLengths-1:0][LenW-1:0] lens;
    stim_row_t row;
    for (int i = 0; i < NumLengths; i++) report_len[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cur_phase = 2'd0;
    set_idling(0);
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.phase != cur_phase) begin
        settle();
        if (row.phase == 2'd1)
          configure(1'b1, {24'hFF_FFFF, 24'd0, 24'd40, 24'd6, 24'd8, 24'd8}, 1'b0);
        else
          configure(1'b0, {24'hFF_FFFF, 24'd0, 24'd8, 24'd3, 24'd1, 24'd1}, 1'b1);
        cur_phase = row.phase;
      end
      offer_request(row.data, row.size, row.last);
      hash_request(row.data, row.size, row.last, !row.typed);
      // typed rows are short bodies: one result, hash zero
      if (row.typed) queue_result('{row.kind, row.covered, '0, 1'b1});
    end

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      mode = (p % 3 == 1) ? 1'b0 : 1'b1;
      for (int i = 0; i < NumLengths; i++) begin
        if (p == 0) lens[i] = '0;
        else if (p == 1) lens[i] = 24'hFF_FFFF;
        else lens[i] = pick_length(mode);
      end
      configure(mode, lens, p == 3);
      set_idling(p % 4);
      if (p == 4) hold_on = 1'b1;
      items_in_phase = 0;
      while (items_in_phase < PhaseItems) send_body();
    end

    settle();
    if (mismatches == 0 && fingerprints_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mcfh_pkg.sv
rtl/mcfh_hash_core.sv
rtl/masked_code_fingerprint_hash.sv
tb/tb.sv
